// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, masked while reset is asserted.
`define CHK_ALWAYS(label, clk_s, rst_n_s, expr, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (expr)) else $error(msg);

// Concurrent implication on clk, masked while reset is asserted.
`define CHK_IMPL(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/tfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared constants, types and command structs for the triangle rasterizer.
// ----------------------------------------------------------------------------
package tfr_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int WIDTH_BITS     = 13;
	localparam int COLOR_BITS     = 24;
	localparam int INDEX_BITS     = 24;
	localparam int CFG_IDX_BITS   = 1;
	localparam int CFG_DATA_BITS  = 24;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUTLINE_COLOR = 1'd1;

	localparam logic [WIDTH_BITS-1:0] IMAGE_WIDTH_RST   = 13'd4096;
	localparam logic [COLOR_BITS-1:0] OUTLINE_COLOR_RST = 24'hFFFFFF;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	// Controller -> datapath commands.
	typedef struct packed {
		logic load;       // latch triangle and sort
		logic span_start; // begin span computation for current row
		logic fill_emit;  // emit fill pixel and advance cursor
		logic line_start; // set up line given by line_sel
		logic [1:0] line_sel;
		logic line_emit;  // emit line pixel and advance
		logic last;       // flag last pixel on emit
	} tfr_cmd_t;

	// Datapath -> controller status.
	typedef struct packed {
		logic has_fill;   // H > 0
		logic span_busy;  // divider still working
		logic span_done;  // cursor reached span end
		logic rows_done;  // next row is past the last fill row
		logic line_done;  // current point equals end point
		logic out_full;   // output register holds a word
	} tfr_sts_t;

endpackage

`default_nettype wire

// ===== sv/tfr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_in_if / tfr_out_if
// Valid/ready channels carrying the input and result words.
// ----------------------------------------------------------------------------
interface tfr_in_if #(parameter int CB = tfr_pkg::COORD_BITS_DEF);
	logic valid;
	logic ready;
	logic kind;
	logic [CB-1:0] vert_a_x;
	logic [CB-1:0] vert_a_y;
	logic [CB-1:0] vert_b_x;
	logic [CB-1:0] vert_b_y;
	logic [CB-1:0] vert_c_x;
	logic [CB-1:0] vert_c_y;
	logic [tfr_pkg::COLOR_BITS-1:0] fill_color;
	modport source (output valid, kind, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
		vert_c_x, vert_c_y, fill_color, input ready);
	modport sink (input valid, kind, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
		vert_c_x, vert_c_y, fill_color, output ready);
endinterface

interface tfr_out_if #(parameter int CB = tfr_pkg::COORD_BITS_DEF);
	logic valid;
	logic ready;
	logic [CB-1:0] pixel_x;
	logic [CB-1:0] pixel_y;
	logic [tfr_pkg::INDEX_BITS-1:0] pixel_index;
	logic [tfr_pkg::COLOR_BITS-1:0] pixel_color;
	logic is_outline;
	logic last_pixel;
	modport source (output valid, pixel_x, pixel_y, pixel_index, pixel_color,
		is_outline, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_index, pixel_color,
		is_outline, last_pixel, output ready);
endinterface

`default_nettype wire

// ===== sv/tfr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_div
// Restoring divider, one quotient bit per cycle, floor semantics for a signed
// numerator over a positive denominator. A zero denominator gives 0.
// ----------------------------------------------------------------------------
module tfr_div #(
	parameter int NB = 26,
	parameter int DB = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [NB-1:0] num,
	input  wire logic        [DB-1:0] den,
	output logic                      busy,
	output logic signed [NB-1:0]      quo
);
	localparam int CW = $clog2(NB + 1);

	logic [NB-1:0] mag_q;
	logic [NB-1:0] q_q;
	logic [DB:0]   rem_q;
	logic [DB-1:0] den_q;
	logic          neg_q;
	logic          zero_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [DB:0]   shifted;
	logic          take;
	logic [NB-1:0] qn;
	logic          rem_nz;

	assign shifted = {rem_q[DB-1:0], mag_q[NB-1]};
	assign take    = shifted >= {1'b0, den_q};
	assign busy    = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CW'(NB);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q  <= num[NB-1] ? NB'(-num) : NB'(num);
			neg_q  <= num[NB-1];
			zero_q <= (den == '0);
			den_q  <= den;
			rem_q  <= '0;
			q_q    <= '0;
		end else if (run_q) begin
			mag_q <= {mag_q[NB-2:0], 1'b0};
			q_q   <= {q_q[NB-2:0], take};
			rem_q <= take ? (shifted - {1'b0, den_q}) : shifted;
		end
	end

	// floor: negative with remainder rounds one further down
	assign rem_nz = (rem_q != '0);
	assign qn     = NB'(-q_q) - NB'(rem_nz);
	assign quo    = zero_q ? '0 : (neg_q ? $signed(qn) : $signed(q_q));
endmodule

`default_nettype wire

// ===== sv/tfr_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_datapath
// Vertex store, span setup with a shared serial divider, span cursor,
// Bresenham stepper and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tfr_datapath #(
	parameter int CB = tfr_pkg::COORD_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  tfr_pkg::tfr_cmd_t       cmd,
	output tfr_pkg::tfr_sts_t       sts,
	input  wire logic [CB-1:0]      ax, ay, bx, by, cx, cy,
	input  wire logic [tfr_pkg::COLOR_BITS-1:0] fcol,
	input  wire logic [tfr_pkg::WIDTH_BITS-1:0] img_w,
	input  wire logic [tfr_pkg::COLOR_BITS-1:0] ocol,
	tfr_out_if.source               dout
);
	localparam int SB = CB + 2;        // signed coordinate arithmetic
	localparam int NB = 2 * CB + 2;    // product width
	localparam int EB = CB + 2;        // bresenham error

	typedef enum logic [1:0] {SP_IDLE, SP_DIVA, SP_DIVB, SP_DONE} sp_t;

	logic [CB-1:0] sx0_q, sy0_q, sx1_q, sy1_q, sx2_q, sy2_q;
	logic [CB-1:0] ox_q [3];
	logic [CB-1:0] oy_q [3];
	logic [tfr_pkg::COLOR_BITS-1:0] fcol_q;
	logic [CB-1:0] row_q;
	logic [CB-1:0] cur_q, end_q;
	logic signed [SB-1:0] a_q;
	sp_t  sp_q;

	logic [CB-1:0] lx_q, ly_q, lex_q, ley_q, ldx_q, ldy_q;
	logic [1:0]    ldir_q;
	logic signed [EB-1:0] lerr_q;

	logic          ov_q;
	logic [CB-1:0] opx_q, opy_q;
	logic [tfr_pkg::COLOR_BITS-1:0] opc_q;
	logic          oout_q, olast_q;

	// sorting network on load inputs
	logic [CB-1:0] x0a, y0a, x1a, y1a, x0b, y0b, x2b, y2b, x1c, y1c, x2c, y2c;
	always_comb begin
		if (ay > by) begin
			x0a = bx; y0a = by; x1a = ax; y1a = ay;
		end else begin
			x0a = ax; y0a = ay; x1a = bx; y1a = by;
		end
		if (y0a > cy) begin
			x0b = cx; y0b = cy; x2b = x0a; y2b = y0a;
		end else begin
			x0b = x0a; y0b = y0a; x2b = cx; y2b = cy;
		end
		if (y1a > y2b) begin
			x1c = x2b; y1c = y2b; x2c = x1a; y2c = y1a;
		end else begin
			x1c = x1a; y1c = y1a; x2c = x2b; y2c = y2b;
		end
	end

	// span setup operands
	logic [CB-1:0] htot, h1, h2;
	logic          upper;
	logic signed [SB-1:0] dxa, dxb, ib;
	logic signed [NB-1:0] pa, pb;
	logic [CB-1:0] dena, denb;
	logic signed [SB-1:0] baseb;
	assign htot  = sy2_q - sy0_q;
	assign h1    = sy1_q - sy0_q;
	assign h2    = sy2_q - sy1_q;
	assign upper = (row_q > h1) || (h1 == '0);
	assign dxa   = $signed({2'b0, sx2_q}) - $signed({2'b0, sx0_q});
	assign dxb   = upper ? $signed({2'b0, sx2_q}) - $signed({2'b0, sx1_q})
	                     : $signed({2'b0, sx1_q}) - $signed({2'b0, sx0_q});
	assign ib    = upper ? $signed({2'b0, row_q}) - $signed({2'b0, h1})
	                     : $signed({2'b0, row_q});
	assign baseb = upper ? $signed({2'b0, sx1_q}) : $signed({2'b0, sx0_q});
	assign dena  = htot;
	assign denb  = upper ? h2 : h1;

	// one multiply per setup pass, registered before the divider
	logic signed [NB-1:0] prod_q;
	logic [CB-1:0]        den_q;
	logic                 mul_v_q;
	logic                 dstart;
	logic                 dbusy;
	logic signed [NB-1:0] dquo;
	logic                 dbusy_d_q;
	logic                 ddone;
	assign pa = NB'(dxa) * NB'($signed({2'b0, row_q}));
	assign pb = NB'(dxb) * NB'(ib);

	tfr_div #(.NB(NB), .DB(CB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(prod_q), .den(den_q),
		.busy(dbusy), .quo(dquo)
	);
	assign dstart = mul_v_q;
	assign ddone  = dbusy_d_q && !dbusy;

	logic signed [SB-1:0] a_new, b_new;
	assign a_new = $signed({2'b0, sx0_q}) + SB'(dquo);
	assign b_new = baseb + SB'(dquo);

	// bresenham
	logic signed [EB-1:0] e_sdx, e_dy;
	logic step_x, step_y;
	assign e_sdx  = -$signed({2'b0, ldx_q});
	assign e_dy   = $signed({2'b0, ldy_q});
	assign step_x = lerr_q > e_sdx;
	assign step_y = lerr_q < e_dy;

	logic [CB-1:0] px, py, qx, qy;
	logic [1:0]    nsel;
	logic [CB-1:0] ndx, ndy;
	always_comb begin
		px = ox_q[cmd.line_sel];
		py = oy_q[cmd.line_sel];
		case (cmd.line_sel)
			2'd0: nsel = 2'd1;
			2'd1: nsel = 2'd2;
			default: nsel = 2'd0;
		endcase
		qx  = ox_q[nsel];
		qy  = oy_q[nsel];
		ndx = (qx > px) ? qx - px : px - qx;
		ndy = (qy > py) ? qy - py : py - qy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q      <= SP_IDLE;
			mul_v_q   <= 1'b0;
			dbusy_d_q <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			dbusy_d_q <= dbusy;
			mul_v_q   <= 1'b0;
			if (ov_q && dout.ready) ov_q <= 1'b0;
			if (cmd.fill_emit || cmd.line_emit) ov_q <= 1'b1;
			if (cmd.load) begin
				sp_q <= SP_IDLE;
			end else if (cmd.span_start) begin
				sp_q    <= SP_DIVA;
				mul_v_q <= 1'b1;
			end else begin
				case (sp_q)
					SP_DIVA: if (ddone) begin
						sp_q    <= SP_DIVB;
						mul_v_q <= 1'b1;
					end
					SP_DIVB: if (ddone) sp_q <= SP_DONE;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ox_q[0] <= ax; oy_q[0] <= ay;
			ox_q[1] <= bx; oy_q[1] <= by;
			ox_q[2] <= cx; oy_q[2] <= cy;
			sx0_q <= x0b; sy0_q <= y0b;
			sx1_q <= x1c; sy1_q <= y1c;
			sx2_q <= x2c; sy2_q <= y2c;
			fcol_q <= fcol;
			row_q  <= '0;
		end
		if (cmd.span_start) begin
			prod_q <= pa;
			den_q  <= dena;
		end else if (sp_q == SP_DIVA && ddone) begin
			a_q    <= a_new;
			prod_q <= pb;
			den_q  <= denb;
		end
		if (sp_q == SP_DIVB && ddone) begin
			if (a_q > b_new) begin
				cur_q <= CB'(b_new); end_q <= CB'(a_q);
			end else begin
				cur_q <= CB'(a_q); end_q <= CB'(b_new);
			end
		end
		if (cmd.fill_emit) begin
			opx_q   <= cur_q;
			opy_q   <= sy0_q + row_q;
			opc_q   <= fcol_q;
			oout_q  <= 1'b0;
			olast_q <= 1'b0;
			if (cur_q == end_q) row_q <= row_q + 1'b1;
			else cur_q <= cur_q + 1'b1;
		end
		if (cmd.line_start) begin
			lx_q   <= px;  ly_q <= py;
			lex_q  <= qx;  ley_q <= qy;
			ldx_q  <= ndx; ldy_q <= ndy;
			ldir_q <= {!(py < qy), !(px < qx)};
			lerr_q <= (ndx > ndy) ? $signed({2'b0, ndx >> 1})
			                      : -$signed({2'b0, ndy >> 1});
		end else if (cmd.line_emit) begin
			opx_q   <= lx_q;
			opy_q   <= ly_q;
			opc_q   <= ocol;
			oout_q  <= 1'b1;
			olast_q <= cmd.last;
			if (!sts.line_done) begin
				lerr_q <= lerr_q - (step_x ? e_dy : '0)
				                 + (step_y ? $signed({2'b0, ldx_q}) : '0);
				if (step_x) lx_q <= ldir_q[0] ? lx_q - 1'b1 : lx_q + 1'b1;
				if (step_y) ly_q <= ldir_q[1] ? ly_q - 1'b1 : ly_q + 1'b1;
			end
		end
	end

	// index product formed from the output word, modulo 2^24
	logic [tfr_pkg::INDEX_BITS-1:0] idx;
	assign idx = tfr_pkg::INDEX_BITS'(opx_q)
	           + tfr_pkg::INDEX_BITS'(opy_q) * tfr_pkg::INDEX_BITS'(img_w);

	assign sts.has_fill  = (y2c != y0b);
	assign sts.span_busy = (sp_q == SP_DIVA) || (sp_q == SP_DIVB) || cmd.span_start;
	assign sts.span_done = (cur_q == end_q);
	assign sts.rows_done = (row_q + 1'b1) >= htot;
	assign sts.line_done = (lx_q == lex_q) && (ly_q == ley_q);
	assign sts.out_full  = ov_q;

	assign dout.valid       = ov_q;
	assign dout.pixel_x     = opx_q;
	assign dout.pixel_y     = opy_q;
	assign dout.pixel_index = idx;
	assign dout.pixel_color = opc_q;
	assign dout.is_outline  = oout_q;
	assign dout.last_pixel  = olast_q;

	`CHK_IMPL(a_emit_free, clk, arst_n, cmd.fill_emit || cmd.line_emit, !ov_q || dout.ready, "emit overwrote a waiting word")
	`CHK_IMPL(a_no_emit_busy, clk, arst_n, cmd.fill_emit, !(sp_q == SP_DIVA || sp_q == SP_DIVB), "fill emitted during span setup")
	`CHK_IMPL(a_last_outline, clk, arst_n, ov_q && olast_q, oout_q, "last pixel is not an outline pixel")
endmodule

`default_nettype wire

// ===== sv/tfr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_ctrl
// Phase sequencer: load, fill rows if any, then three outline lines.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tfr_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic         in_kind,
	output logic              in_ready,
	input  wire logic         out_ready,
	output tfr_pkg::tfr_cmd_t cmd,
	input  tfr_pkg::tfr_sts_t sts
);
	typedef enum logic [2:0] {ST_IDLE, ST_FILL, ST_LINE0, ST_LINE1, ST_LINE2} st_t;
	st_t st_q;
	logic setup_q;   // line setup pending (one cycle)
	logic pend_q;    // load landed on the last edge
	logic fill_ok_q; // that load has fill rows
	logic kick_q;    // span setup for the next row pending
	logic room;
	logic acc;
	logic kick;

	// span setup starts once row_q and the sorted vertices are in place
	assign kick     = kick_q || (pend_q && fill_ok_q);
	assign room     = !sts.out_full || out_ready;
	assign in_ready = !sts.span_busy && !setup_q && !pend_q && room;
	assign acc      = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		case (st_q)
			ST_LINE0: cmd.line_sel = 2'd0;
			ST_LINE1: cmd.line_sel = 2'd1;
			default:  cmd.line_sel = 2'd2;
		endcase
		cmd.line_start = setup_q;
		cmd.span_start = kick;
		if (acc && in_kind == tfr_pkg::KIND_LOAD) begin
			cmd.load = 1'b1;
		end else if (acc) begin
			case (st_q)
				ST_FILL: begin
					cmd.fill_emit = 1'b1;
				end
				ST_LINE0, ST_LINE1, ST_LINE2: begin
					cmd.line_emit = 1'b1;
					cmd.last = sts.line_done && (st_q == ST_LINE2);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			setup_q <= 1'b0;
		end else begin
			setup_q <= 1'b0;
			if (cmd.load) begin
				// sorted vertices land this edge; span or line setup follows
				st_q    <= ST_FILL;
				setup_q <= 1'b0;
			end else if (st_q == ST_FILL && pend_q) begin
				if (!fill_ok_q) begin
					st_q    <= ST_LINE0;
					setup_q <= 1'b1;
				end
			end else if (cmd.fill_emit && sts.span_done && sts.rows_done) begin
				st_q    <= ST_LINE0;
				setup_q <= 1'b1;
			end else if (cmd.line_emit && sts.line_done) begin
				case (st_q)
					ST_LINE0: begin st_q <= ST_LINE1; setup_q <= 1'b1; end
					ST_LINE1: begin st_q <= ST_LINE2; setup_q <= 1'b1; end
					default:  st_q <= ST_IDLE;
				endcase
			end
		end
	end

	// after load: decide fill or outline once sorted data is in place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 1'b0;
			fill_ok_q <= 1'b0;
			kick_q    <= 1'b0;
		end else begin
			pend_q <= cmd.load;
			if (cmd.load) fill_ok_q <= sts.has_fill;
			kick_q <= cmd.fill_emit && sts.span_done && !sts.rows_done;
		end
	end

	`CHK_IMPL(a_setup_line, clk, arst_n, setup_q, st_q == ST_LINE0 || st_q == ST_LINE1 || st_q == ST_LINE2, "line setup outside a line phase")
	`CHK_IMPL(a_no_accept_setup, clk, arst_n, setup_q || pend_q || kick_q, !acc, "word taken during setup")
	`CHK_ALWAYS(a_one_emit, clk, arst_n, !(cmd.fill_emit && cmd.line_emit), "two emits at once")
endmodule

`default_nettype wire

// ===== sv/triangle_fill_outline_raster_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_fill_outline_raster_unit
// Triangle scanline fill plus Bresenham outline, one pixel word per step.
// ----------------------------------------------------------------------------
// Usage:
//   din carries load words (kind 0: three vertices and a fill color) and step
//   words (kind 1). A load gives no output and restarts any run. Each step
//   while a run is active gives one pixel word on dout; steps while idle give
//   nothing.
//   Cfg port: index 0 image_width, index 1 outline_color, written when idle.
// Throughput: one step per cycle inside a span or a line while dout is not
//   stalling. At each new fill row, the first one after a load included, the
//   span setup runs two passes through the shared serial divider and din is
//   held off until both are done. At each line start din is held off while
//   the line is set up, and after the load of a flat triangle also while the
//   load is resolved.
// Output: a pixel word is registered in the cycle after its step is taken.
// Reset: image_width 4096, outline_color white, no active run.
// Stall: the output register holds its word; din takes a word only when the
//   register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module triangle_fill_outline_raster_unit #(
	parameter int COORD_BITS = tfr_pkg::COORD_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tfr_in_if.sink    din,
	tfr_out_if.source dout,
	input  wire logic cfg_we,
	input  wire logic [tfr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [tfr_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	logic [tfr_pkg::WIDTH_BITS-1:0] img_w_q;
	logic [tfr_pkg::COLOR_BITS-1:0] ocol_q;
	tfr_pkg::tfr_cmd_t cmd;
	tfr_pkg::tfr_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= tfr_pkg::IMAGE_WIDTH_RST;
			ocol_q  <= tfr_pkg::OUTLINE_COLOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tfr_pkg::REG_IMAGE_WIDTH:   img_w_q <= cfg_data[tfr_pkg::WIDTH_BITS-1:0];
				tfr_pkg::REG_OUTLINE_COLOR: ocol_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	tfr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(din.valid), .in_kind(din.kind),
		.in_ready(din.ready), .out_ready(dout.ready), .cmd(cmd), .sts(sts)
	);

	tfr_datapath #(.CB(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.ax(din.vert_a_x), .ay(din.vert_a_y), .bx(din.vert_b_x), .by(din.vert_b_y),
		.cx(din.vert_c_x), .cy(din.vert_c_y), .fcol(din.fill_color),
		.img_w(img_w_q), .ocol(ocol_q), .dout(dout)
	);
endmodule

`default_nettype wire
